>>> rtl/qdh_pkg.sv
package qdh_pkg;

  localparam int LONG_CLAMP = 20;
  localparam int MAX_ID_BYTES_DEF = 20;
  localparam int LONG_ID_START = 6;
  localparam logic [4:0] SHORT_LEN_RESET = 5'd16;
  localparam logic [4:0] POS_MAX = 5'd31;
  localparam logic [2:0] LONG_PREFIX_LAST = 3'd4;
  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

  typedef struct packed {
    logic [4:0] len;
    logic       long_hdr;
    logic       zero_fill;
  } summary_t;

  // multiply by the prime 2^40 + 0x1b3 as shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] v);
    logic [63:0] x;
    x = h ^ {56'd0, v};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

>>> rtl/qdh_if.sv
interface qdh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;
  modport source (output valid, output packet_byte, output end_of_packet, input ready);
  modport sink (input valid, input packet_byte, input end_of_packet, output ready);
endinterface

interface qdh_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  id_byte;
  logic        byte_present;
  logic [4:0]  id_length;
  logic        long_form;
  logic [63:0] id_hash;
  logic        last_of_run;
  modport source (output valid, output id_byte, output byte_present, output id_length,
                  output long_form, output id_hash, output last_of_run, input ready);
  modport sink (input valid, input id_byte, input byte_present, input id_length,
                input long_form, input id_hash, input last_of_run, output ready);
endinterface

interface qdh_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] short_id_length;
  modport source (output valid, output short_id_length, input ready);
  modport sink (input valid, input short_id_length, output ready);
endinterface

>>> rtl/quic_dcid_extract_and_hash.sv
// channel  dir  beat contents
// cfg      in   short_id_length
// pkt      in   packet_byte, end_of_packet
// id       out  id_byte, byte_present, id_length, long_form, id_hash, last_of_run
//
// one packet byte per cycle while collecting; the id bytes go to a one-port-read ram
// at packet end a run starts: one beat per id byte, or a single empty beat for length 0;
// each beat reads the ram (registered read) then hashes and loads the output register
// pkt.ready is low during the run; the next packet starts while the last beat waits
// reset sets short_id_length to 16; the ram needs no clearing
// a stalled output beat holds the run in place
module quic_dcid_extract_and_hash #(
  parameter int MAX_ID_BYTES = qdh_pkg::MAX_ID_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  qdh_cfg_if.sink   cfg,
  qdh_in_if.sink    pkt,
  qdh_out_if.source id
);
  import qdh_pkg::*;

  localparam int ADDR_W = (MAX_ID_BYTES > 1) ? $clog2(MAX_ID_BYTES) : 1;

  logic              busy;
  logic              start;
  summary_t          summ;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  qdh_parse #(.MAX_ID_BYTES(MAX_ID_BYTES)) u_parse (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .pkt   (pkt),
    .busy  (busy),
    .start (start),
    .summ  (summ),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  qdh_ram #(.WIDTH(8), .DEPTH(MAX_ID_BYTES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  qdh_emit #(.MAX_ID_BYTES(MAX_ID_BYTES)) u_emit (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .summ  (summ),
    .busy  (busy),
    .raddr (raddr),
    .rdata (rdata),
    .id    (id)
  );

endmodule

>>> rtl/qdh_ram.sv
module qdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/qdh_parse.sv
module qdh_parse #(
  parameter int MAX_ID_BYTES = 20,
  localparam int ADDR_W = (MAX_ID_BYTES > 1) ? $clog2(MAX_ID_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  qdh_cfg_if.sink             cfg,
  qdh_in_if.sink              pkt,
  input  logic                busy,
  output logic                start,
  output qdh_pkg::summary_t   summ,
  output logic                we,
  output logic [ADDR_W-1:0]   waddr,
  output logic [7:0]          wdata
);
  import qdh_pkg::*;

  localparam int CAP = (MAX_ID_BYTES < LONG_CLAMP) ? MAX_ID_BYTES : LONG_CLAMP;
  localparam logic [4:0] CAP5 = 5'(CAP);
  localparam logic [4:0] START5 = 5'(LONG_ID_START);
  localparam logic [5:0] START6 = 6'(LONG_ID_START);

  logic       [4:0] short_len;
  logic       [4:0] pos;
  logic             top;
  logic       [4:0] declared;

  logic             accept;
  logic             top_eff;
  logic       [4:0] decl_eff;
  logic       [4:0] clamp_b;
  logic       [4:0] pos_m1;
  logic       [4:0] pos_m6;
  logic       [4:0] wsel;
  logic       [5:0] n;
  logic       [4:0] slen;

  assign cfg.ready = 1'b1;
  assign pkt.ready = !busy;
  assign accept = pkt.valid && pkt.ready;

  assign clamp_b = (pkt.packet_byte > 8'(CAP)) ? CAP5 : pkt.packet_byte[4:0];
  assign top_eff = (pos == 5'd0) ? pkt.packet_byte[7] : top;
  assign decl_eff = (pos == START5 - 5'd1) ? clamp_b : declared;
  assign pos_m1 = pos - 5'd1;
  assign pos_m6 = pos - START5;

  // id store writes
  always_comb begin
    we = 1'b0;
    wsel = pos_m1;
    if (accept) begin
      if (top) begin
        if (pos >= 5'd1 && pos <= 5'(LONG_PREFIX_LAST) && pos_m1 < CAP5) begin
          we = 1'b1;
        end else if (pos >= START5 && pos_m6 < CAP5) begin
          we = 1'b1;
          wsel = pos_m6;
        end
      end else if (pos >= 5'd1 && pos_m1 < CAP5) begin
        we = 1'b1;
      end
    end
  end

  assign waddr = wsel[ADDR_W-1:0];
  assign wdata = pkt.packet_byte;

  // end of packet summary
  assign n = {1'b0, pos} + 6'd1;
  assign slen = (short_len > CAP5) ? CAP5 : short_len;

  always_comb begin
    summ.long_hdr = top_eff && (n >= START6);
    summ.zero_fill = 1'b0;
    if (summ.long_hdr) begin
      summ.len = (n >= START6 + {1'b0, decl_eff}) ? decl_eff : 5'd0;
    end else begin
      summ.len = slen;
      summ.zero_fill = n < (6'd1 + {1'b0, slen});
    end
  end

  assign start = accept && pkt.end_of_packet;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_len <= SHORT_LEN_RESET;
      pos <= 5'd0;
      top <= 1'b0;
      declared <= 5'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        short_len <= cfg.short_id_length;
      end
      if (accept) begin
        if (pkt.end_of_packet) begin
          pos <= 5'd0;
          top <= 1'b0;
          declared <= 5'd0;
        end else begin
          pos <= (pos == POS_MAX) ? POS_MAX : pos + 5'd1;
          top <= top_eff;
          declared <= decl_eff;
        end
      end
    end
  end

endmodule

>>> rtl/qdh_emit.sv
module qdh_emit #(
  parameter int MAX_ID_BYTES = 20,
  localparam int ADDR_W = (MAX_ID_BYTES > 1) ? $clog2(MAX_ID_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  qdh_pkg::summary_t   summ,
  output logic                busy,
  output logic [ADDR_W-1:0]   raddr,
  input  logic [7:0]          rdata,
  qdh_out_if.source           id
);
  import qdh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t      state;
  summary_t    cur;
  logic [4:0]  idx;
  logic [63:0] hash;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_present;
  logic [4:0]  out_len;
  logic        out_long;
  logic [63:0] out_hash;
  logic        out_last;

  logic        free;
  logic        load;
  logic [7:0]  v;
  logic [63:0] hash_next;
  logic        last;

  assign busy = (state != S_IDLE);
  assign raddr = idx[ADDR_W-1:0];
  assign free = !out_valid || id.ready;
  assign load = (state == S_LOAD) && free;
  assign v = cur.zero_fill ? 8'd0 : rdata;
  assign hash_next = fnv_step(hash, v);
  assign last = (idx + 5'd1 == cur.len);

  assign id.valid = out_valid;
  assign id.id_byte = out_byte;
  assign id.byte_present = out_present;
  assign id.id_length = out_len;
  assign id.long_form = out_long;
  assign id.id_hash = out_hash;
  assign id.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (id.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (free) begin
            state <= (cur.len == 5'd0 || last) ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // run bookkeeping and output beat payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur <= summ;
      idx <= 5'd0;
      hash <= FNV_BASIS;
    end
    if (load) begin
      out_long <= cur.long_hdr;
      if (cur.len == 5'd0) begin
        out_byte <= 8'd0;
        out_present <= 1'b0;
        out_len <= 5'd0;
        out_hash <= FNV_BASIS;
        out_last <= 1'b1;
      end else begin
        out_byte <= v;
        out_present <= 1'b1;
        out_len <= last ? cur.len : 5'd0;
        out_hash <= last ? hash_next : 64'd0;
        out_last <= last;
        hash <= hash_next;
        idx <= idx + 5'd1;
      end
    end
  end

endmodule

>>> verif/qdh_tb_pkg.sv
`timescale 1ns / 1ps

package qdh_tb_pkg;
  import qdh_pkg::*;

  localparam int ID_CAP = (LONG_CLAMP < MAX_ID_BYTES_DEF) ? LONG_CLAMP : MAX_ID_BYTES_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0]  id_byte;
    logic        byte_present;
    logic [4:0]  id_length;
    logic        long_form;
    logic [63:0] id_hash;
    logic        last_of_run;
  } id_beat_t;

  class dcid_scoreboard;
    logic [4:0] short_len;
    int         pos;
    logic       top_bit;
    int         decl_len;
    logic [7:0] id_bytes [ID_CAP];
    id_beat_t   pending_beats [$];
    int         errors;
    int         beats_checked;
    int         runs;
    int         empty_runs;
    int         long_runs;

    function new();
      short_len = SHORT_LEN_RESET;
      errors = 0;
      beats_checked = 0;
      runs = 0;
      empty_runs = 0;
      long_runs = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      pos = 0;
      top_bit = 1'b0;
      decl_len = 0;
      foreach (id_bytes[i]) id_bytes[i] = 8'd0;
    endfunction

    function void set_short_len(logic [4:0] v);
      short_len = v;
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    function void queue_beat(id_beat_t beat);
      pending_beats.insert(pending_beats.size(), beat);
    endfunction

    // one accepted packet beat; queues the id run at packet end
    function void note_byte(logic [7:0] b, logic eop);
      int p, n, len;
      logic is_long, zero_fill;
      logic [63:0] h;
      id_beat_t beat;
      p = pos;
      if (p == 0) top_bit = b[7];
      if (p == 5) decl_len = (int'(b) > ID_CAP) ? ID_CAP : int'(b);
      if (top_bit) begin
        if (p >= 1 && p <= 4 && p - 1 < ID_CAP) id_bytes[p - 1] = b;
        else if (p >= 6 && p - 6 < ID_CAP) id_bytes[p - 6] = b;
      end else if (p >= 1 && p - 1 < ID_CAP) begin
        id_bytes[p - 1] = b;
      end
      if (pos < int'(POS_MAX)) pos++;
      if (!eop) return;

      n = p + 1;
      is_long = top_bit && n >= 6;
      zero_fill = 1'b0;
      if (is_long) begin
        len = (n >= 6 + decl_len) ? decl_len : 0;
      end else begin
        len = (int'(short_len) > ID_CAP) ? ID_CAP : int'(short_len);
        zero_fill = (n < 1 + len);
      end

      h = FNV_BASIS;
      for (int i = 0; i < len; i++) begin
        h = (h ^ {56'd0, (zero_fill ? 8'd0 : id_bytes[i])}) * FNV_PRIME;
      end

      runs++;
      if (is_long) long_runs++;
      if (len == 0) begin
        empty_runs++;
        beat = '{8'd0, 1'b0, 5'd0, is_long, h, 1'b1};
        queue_beat(beat);
      end else begin
        for (int i = 0; i < len; i++) begin
          beat.id_byte = zero_fill ? 8'd0 : id_bytes[i];
          beat.byte_present = 1'b1;
          beat.id_length = (i == len - 1) ? 5'(len) : 5'd0;
          beat.long_form = is_long;
          beat.id_hash = (i == len - 1) ? h : 64'd0;
          beat.last_of_run = (i == len - 1);
          queue_beat(beat);
        end
      end
      clear_packet();
    endfunction

    function void check_beat(id_beat_t got);
      id_beat_t want;
      if (pending_beats.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected id beat: byte %02h present %0d len %0d long %0d hash %016h last %0d",
                   got.id_byte, got.byte_present, got.id_length, got.long_form, got.id_hash,
                   got.last_of_run);
        return;
      end
      want = pending_beats.pop_front();
      beats_checked++;
      if (got.id_byte !== want.id_byte || got.byte_present !== want.byte_present ||
          got.id_length !== want.id_length || got.long_form !== want.long_form ||
          got.id_hash !== want.id_hash || got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("id beat mismatch at beat %0d", beats_checked);
          $display("  expected byte %02h present %0d len %0d long %0d hash %016h last %0d",
                   want.id_byte, want.byte_present, want.id_length, want.long_form,
                   want.id_hash, want.last_of_run);
          $display("  actual   byte %02h present %0d len %0d long %0d hash %016h last %0d",
                   got.id_byte, got.byte_present, got.id_length, got.long_form,
                   got.id_hash, got.last_of_run);
        end
      end
    endfunction
  endclass

endpackage

>>> verif/quic_dcid_extract_and_hash_tb.sv
`timescale 1ns / 1ps

module quic_dcid_extract_and_hash_tb;
  import qdh_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_CYCLES = 64;
  localparam int PHASE_BYTES = 26;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  qdh_cfg_if cfg_ch ();
  qdh_in_if  pkt_ch ();
  qdh_out_if id_ch ();

  quic_dcid_extract_and_hash dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .pkt (pkt_ch),
    .id  (id_ch)
  );

  dcid_scoreboard sb;
  logic [7:0]     frame [$];
  logic [4:0]     cur_short_len;
  int             bytes_sent;
  int             frames_sent;
  int             hold_req;
  int             cycles;
  bit             no_gap;
  bit             snd_burst;
  bit             rcv_burst;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    frame.insert(frame.size(), b);
  endfunction

  task automatic send_frame();
    int gap;
    for (int i = 0; i < frame.size(); i++) begin
      gap = no_gap ? 0 : draw_gap(snd_burst);
      if (gap > 0) begin
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      pkt_ch.valid <= 1'b1;
      pkt_ch.packet_byte <= frame[i];
      pkt_ch.end_of_packet <= (i == frame.size() - 1);
      do @(posedge clk); while (!pkt_ch.ready);
      sb.note_byte(frame[i], i == frame.size() - 1);
      bytes_sent++;
    end
    frames_sent++;
  endtask

  // drop valid, wait for every id beat, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    pkt_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_short_len(input logic [4:0] v);
    settle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.short_id_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_short_len(v);
    cur_short_len = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic make_random_frame();
    int kind, d, n, slen;
    frame.delete();
    kind = $urandom_range(0, 99);
    slen = (int'(cur_short_len) > ID_CAP) ? ID_CAP : int'(cur_short_len);
    if (kind < 45) begin
      add_byte(8'h80 | 8'($urandom_range(0, 127)));
      repeat (4) add_byte(8'($urandom));
      d = ($urandom_range(0, 7) == 0) ? $urandom_range(ID_CAP + 1, 255)
                                      : $urandom_range(0, ID_CAP);
      add_byte(8'(d));
      n = ((d > ID_CAP) ? ID_CAP : d) + $urandom_range(0, 3);
      repeat (n) add_byte(8'($urandom));
    end else if (kind < 80) begin
      add_byte(8'($urandom_range(0, 127)));
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, slen) : slen + $urandom_range(0, 3);
      repeat (n) add_byte(8'($urandom));
    end else if (kind < 92) begin
      // long header cut off early
      add_byte(8'h80 | 8'($urandom_range(0, 127)));
      repeat ($urandom_range(0, 10)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
    end
  endtask

  initial begin : id_sink
    int stall, n;
    id_beat_t got;
    id_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        id_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      stall = draw_gap(rcv_burst);
      if (stall > 0) begin
        id_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      id_ch.ready <= 1'b1;
      do @(posedge clk); while (!id_ch.valid && hold_req == 0);
      if (id_ch.valid) begin
        got.id_byte = id_ch.id_byte;
        got.byte_present = id_ch.byte_present;
        got.id_length = id_ch.id_length;
        got.long_form = id_ch.long_form;
        got.id_hash = id_ch.id_hash;
        got.last_of_run = id_ch.last_of_run;
        sb.check_beat(got);
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [4:0] plan [5];
    int phase_start;
    rst = 1'b1;
    pkt_ch.valid = 1'b0;
    pkt_ch.packet_byte = 8'd0;
    pkt_ch.end_of_packet = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.short_id_length = 5'd0;
    hold_req = 0;
    no_gap = 1'b0;
    snd_burst = 1'b0;
    rcv_burst = 1'b0;
    bytes_sent = 0;
    frames_sent = 0;
    cur_short_len = qdh_pkg::SHORT_LEN_RESET;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // long header, exact length
    frame = '{8'hC3, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h08,
              8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88};
    send_frame();
    // oversized declared length, clamped
    frame = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    for (int i = 0; i < ID_CAP; i++) add_byte(i[0] ? 8'hFF : 8'h00);
    add_byte(8'hA5);
    add_byte(8'h5A);
    send_frame();
    // long header ending inside the id
    frame = '{8'h80, 8'h01, 8'h02, 8'h03, 8'h04, 8'h09, 8'hAA, 8'hBB};
    send_frame();
    // long header with zero length
    frame = '{8'hC0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h5A};
    send_frame();
    // one byte with top bit: short path, zero filled
    frame = '{8'hFF};
    send_frame();
    frame = '{8'h40};
    for (int i = 0; i < 16; i++) add_byte(8'(i * 17));
    send_frame();
    frame = '{8'h00, 8'h7F, 8'h80, 8'hFE};
    send_frame();
    frame = '{8'h85, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
    send_frame();
    // position saturates
    frame.delete();
    repeat (36) add_byte(8'($urandom_range(0, 127)));
    send_frame();

    plan = '{5'd0, 5'd20, 5'd31, 5'd1, 5'($urandom_range(2, 19))};
    for (int p = 0; p < 5; p++) begin
      write_short_len(plan[p]);
      if (p == 2) begin
        hold_req = HOLD_CYCLES;
        no_gap = 1'b1;
        repeat (5) begin
          make_random_frame();
          send_frame();
        end
        no_gap = 1'b0;
        settle();
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        make_random_frame();
        send_frame();
      end
    end
    settle();

    $display("sent %0d bytes in %0d packets over 6 short id lengths incl. 0, 20 and 31",
             bytes_sent, frames_sent);
    $display("checked %0d id beats: %0d runs, %0d long form, %0d empty ids, %0d errors",
             sb.beats_checked, sb.runs, sb.long_runs, sb.empty_runs, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qdh_pkg.sv
rtl/qdh_if.sv
rtl/qdh_ram.sv
rtl/qdh_parse.sv
rtl/qdh_emit.sv
rtl/quic_dcid_extract_and_hash.sv
verif/qdh_tb_pkg.sv
verif/quic_dcid_extract_and_hash_tb.sv
